### sv/polyline_segment_viewport_cull_defines.svh
// Assertion macros for the polyline viewport cull block.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef POLYLINE_SEGMENT_VIEWPORT_CULL_DEFINES_SVH
`define POLYLINE_SEGMENT_VIEWPORT_CULL_DEFINES_SVH

`ifndef SYNTHESIS
// Clocked check that is off while reset is high.
`define PSVC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Clocked check that also holds during reset.
`define PSVC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PSVC_ASSERT(lbl, clk, rst, prop, msg)
`define PSVC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

### sv/psvc_pkg.sv
// Shared types, codes and constants of the polyline viewport cull block.
// Used by psvc_cross_unit, psvc_seq and polyline_segment_viewport_cull.
package psvc_pkg;

  // Default coordinate width (signed Q16.8).
  localparam int COORD_WIDTH_DEF = 24;
  // Result item data width, padded to a byte.
  localparam int OUT_DATA_W = 8;
  // Configuration register index width.
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VIEW_LEFT,
    REG_VIEW_TOP,
    REG_VIEW_RIGHT,
    REG_VIEW_BOTTOM
  } reg_idx_t;

  // Viewport borders in the order they are tested.
  typedef enum logic [1:0] {
    BORDER_LEFT,
    BORDER_TOP,
    BORDER_RIGHT,
    BORDER_BOTTOM
  } border_t;

  // Which orientation test of a segment pair: border against each segment
  // endpoint, then segment against each border endpoint.
  typedef enum logic [1:0] {
    SIDE_B_A1,
    SIDE_B_A2,
    SIDE_A_B1,
    SIDE_A_B2
  } side_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FINISH
  } state_t;

  // One step issued to the shared multiplier.
  typedef struct packed {
    logic    valid;
    border_t border;
    side_t   side;
    logic    term;
  } step_t;

  // Sign of a cross product.
  typedef struct packed {
    logic neg;
    logic nz;
  } sign_t;

  // Finished orientation test returned to the sequencer.
  typedef struct packed {
    logic  valid;
    side_t side;
    logic  last;
    sign_t sign;
  } side_res_t;

  // Sequencer status toward the top level.
  typedef struct packed {
    logic ready;
    logic done;
    logic hit;
  } seq_ctrl_t;

  // True when two signs are both nonzero and opposite.
  function automatic logic opposite(input sign_t a, input sign_t b);
    return a.nz & b.nz & (a.neg ^ b.neg);
  endfunction

endpackage

### sv/psvc_cross_unit.sv
// Shared cross-product unit: operand select, one multiplier, sign of A - B.
// Depends on psvc_pkg.
module psvc_cross_unit #(
  parameter int COORD_WIDTH = psvc_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  psvc_pkg::step_t               step,
  input  logic signed [COORD_WIDTH-1:0] view_left,
  input  logic signed [COORD_WIDTH-1:0] view_top,
  input  logic signed [COORD_WIDTH-1:0] view_right,
  input  logic signed [COORD_WIDTH-1:0] view_bottom,
  input  logic signed [COORD_WIDTH-1:0] prev_x,
  input  logic signed [COORD_WIDTH-1:0] prev_y,
  input  logic signed [COORD_WIDTH-1:0] cur_x,
  input  logic signed [COORD_WIDTH-1:0] cur_y,
  output psvc_pkg::side_res_t           res
);
  import psvc_pkg::*;

  localparam int DW = COORD_WIDTH + 1;
  localparam int PW = 2 * DW;

  logic signed [COORD_WIDTH-1:0] b1x, b1y, b2x, b2y;
  logic signed [COORD_WIDTH-1:0] ox, oy, ex, ey, px, py;
  logic signed [DW-1:0] d1_next, d2_next, d1, d2;
  logic signed [PW-1:0] prod_next, prod, a_prod;
  logic signed [PW:0]   diff;
  step_t stage1, stage2;
  side_res_t res_next;

  // Border endpoints for the selected border.
  always_comb begin
    case (step.border)
      BORDER_LEFT: begin
        b1x = view_left;  b1y = view_top;
        b2x = view_left;  b2y = view_bottom;
      end
      BORDER_TOP: begin
        b1x = view_left;  b1y = view_top;
        b2x = view_right; b2y = view_top;
      end
      BORDER_RIGHT: begin
        b1x = view_right; b1y = view_top;
        b2x = view_right; b2y = view_bottom;
      end
      default: begin
        b1x = view_left;  b1y = view_bottom;
        b2x = view_right; b2y = view_bottom;
      end
    endcase
  end

  // Origin, end and probe point of the orientation test.
  always_comb begin
    case (step.side)
      SIDE_B_A1: begin
        ox = b1x; oy = b1y; ex = b2x; ey = b2y; px = prev_x; py = prev_y;
      end
      SIDE_B_A2: begin
        ox = b1x; oy = b1y; ex = b2x; ey = b2y; px = cur_x; py = cur_y;
      end
      SIDE_A_B1: begin
        ox = prev_x; oy = prev_y; ex = cur_x; ey = cur_y; px = b1x; py = b1y;
      end
      default: begin
        ox = prev_x; oy = prev_y; ex = cur_x; ey = cur_y; px = b2x; py = b2y;
      end
    endcase
  end

  // First term is (ex - ox) * (py - oy), second is (ey - oy) * (px - ox).
  always_comb begin
    if (step.term) begin
      d1_next = $signed({ey[COORD_WIDTH-1], ey}) - $signed({oy[COORD_WIDTH-1], oy});
      d2_next = $signed({px[COORD_WIDTH-1], px}) - $signed({ox[COORD_WIDTH-1], ox});
    end else begin
      d1_next = $signed({ex[COORD_WIDTH-1], ex}) - $signed({ox[COORD_WIDTH-1], ox});
      d2_next = $signed({py[COORD_WIDTH-1], py}) - $signed({oy[COORD_WIDTH-1], oy});
    end
  end

  // The one shared multiplier.
  assign prod_next = d1 * d2;

  // Exact difference of the two products; only its sign is used.
  assign diff = $signed({a_prod[PW-1], a_prod}) - $signed({prod[PW-1], prod});

  always_comb begin
    res_next.valid    = stage2.valid & stage2.term;
    res_next.side     = stage2.side;
    res_next.last     = (stage2.border == BORDER_BOTTOM) && (stage2.side == SIDE_A_B2);
    res_next.sign.neg = diff[PW];
    res_next.sign.nz  = |diff;
  end

  // Pipeline control.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage1 <= '0;
      stage2 <= '0;
    end else begin
      stage1 <= step;
      stage2 <= stage1;
    end
  end

  // Pipeline data.
  always_ff @(posedge clk) begin
    d1   <= d1_next;
    d2   <= d2_next;
    prod <= prod_next;
    if (stage2.valid && !stage2.term) begin
      a_prod <= prod;
    end
  end

  // Finished orientation test toward the sequencer.
  always_ff @(posedge clk) begin
    res.side <= res_next.side;
    res.last <= res_next.last;
    res.sign <= res_next.sign;
    if (rst) begin
      res.valid <= 1'b0;
    end else begin
      res.valid <= res_next.valid;
    end
  end

endmodule

### sv/psvc_seq.sv
// Sequencer: walks the 32 multiplier steps and folds side signs into a hit.
// Depends on psvc_pkg and the assertion macro header.
`include "polyline_segment_viewport_cull_defines.svh"

module psvc_seq (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  first_point,
  input  logic                  out_free,
  input  psvc_pkg::side_res_t   res,
  output psvc_pkg::step_t       step,
  output psvc_pkg::seq_ctrl_t   ctrl
);
  import psvc_pkg::*;

  state_t state, state_next;
  logic [4:0] step_cnt;
  logic issuing;
  logic hit;
  logic pair_opp;
  sign_t held_sign;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = first_point ? ST_FINISH : ST_RUN;
        end
      end
      ST_RUN: begin
        if (res.valid && res.last) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    ctrl.ready  = (state == ST_IDLE);
    ctrl.done   = (state == ST_FINISH) && out_free;
    ctrl.hit    = hit;
    step.valid  = issuing;
    step.border = border_t'(step_cnt[4:3]);
    step.side   = side_t'(step_cnt[2:1]);
    step.term   = step_cnt[0];
  end

  // State and step issue.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      issuing  <= 1'b0;
      step_cnt <= '0;
    end else begin
      state <= state_next;
      if (start && !first_point) begin
        issuing  <= 1'b1;
        step_cnt <= '0;
      end else if (issuing) begin
        step_cnt <= step_cnt + 5'd1;
        if (&step_cnt) begin
          issuing <= 1'b0;
        end
      end
    end
  end

  // Combine the four side signs of each border into a proper crossing.
  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else if (start) begin
      hit <= 1'b0;
    end else if (res.valid) begin
      case (res.side)
        SIDE_B_A1, SIDE_A_B1: held_sign <= res.sign;
        SIDE_B_A2: pair_opp <= opposite(held_sign, res.sign);
        default: begin
          if (pair_opp && opposite(held_sign, res.sign)) begin
            hit <= 1'b1;
          end
        end
      endcase
    end
  end

  `PSVC_ASSERT(a_step_in_run, clk, rst, step.valid |-> state == ST_RUN, "step outside run")
  `PSVC_ASSERT(a_res_in_run, clk, rst, res.valid |-> state == ST_RUN, "result outside run")
  `PSVC_ASSERT(a_finish_hold, clk, rst, (state == ST_FINISH && !out_free) |=> state == ST_FINISH, "left finish while output busy")

endmodule

### sv/polyline_segment_viewport_cull.sv
// Top level of the polyline viewport cull block: ports, registers, output slot.
// Depends on psvc_pkg, psvc_cross_unit, psvc_seq and the assertion macro header.
//
// Each polyline point enters as one item and leaves one result item that says
// whether the point (first point of a polyline) or the segment from the
// previous point touches the viewport held in the four configuration
// registers. A first point needs no multiplier steps. A later point has its
// segment checked against the four borders with sixteen orientation tests,
// each two products on one shared multiplier, so 32 multiplier steps run
// through the three-stage pipeline before the result is written. The input is
// not ready while an item is in work; a finished result waits in an output
// register, and the next item is taken as soon as the result has been written
// there.
`include "polyline_segment_viewport_cull_defines.svh"

module polyline_segment_viewport_cull #(
  parameter int COORD_WIDTH = psvc_pkg::COORD_WIDTH_DEF,
  localparam int IN_DATA_W = ((2 * COORD_WIDTH + 7) / 8) * 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // point_x [COORD_WIDTH-1:0], point_y [2*COORD_WIDTH-1:COORD_WIDTH], zero pad above
  input  logic [IN_DATA_W-1:0]              s_tdata,
  // first_point [0]
  input  logic                              s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // visible [0], zero pad above
  output logic [psvc_pkg::OUT_DATA_W-1:0]   m_tdata,
  input  logic                              cfg_we,
  input  logic [psvc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [COORD_WIDTH-1:0]            cfg_wdata
);
  import psvc_pkg::*;

  logic signed [COORD_WIDTH-1:0] view_left, view_top, view_right, view_bottom;
  logic signed [COORD_WIDTH-1:0] prev_x, prev_y, cur_x, cur_y;
  logic first;
  logic s_accept;
  logic out_free;
  logic cur_in, prev_in, visible_next, visible;
  step_t step;
  side_res_t res;
  seq_ctrl_t ctrl;

  assign s_accept = s_tvalid & s_tready;
  assign s_tready = ctrl.ready;
  assign out_free = !m_tvalid || m_tready;

  // Viewport registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      view_left   <= '0;
      view_top    <= '0;
      view_right  <= '0;
      view_bottom <= '0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_VIEW_LEFT:   view_left   <= cfg_wdata;
        REG_VIEW_TOP:    view_top    <= cfg_wdata;
        REG_VIEW_RIGHT:  view_right  <= cfg_wdata;
        REG_VIEW_BOTTOM: view_bottom <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Current item capture.
  always_ff @(posedge clk) begin
    if (s_accept) begin
      cur_x <= s_tdata[COORD_WIDTH-1:0];
      cur_y <= s_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
      first <= s_tuser;
    end
  end

  // Previous point moves up once the item is finished.
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_x <= '0;
      prev_y <= '0;
    end else if (ctrl.done) begin
      prev_x <= cur_x;
      prev_y <= cur_y;
    end
  end

  // Inside tests, bounds inclusive.
  assign cur_in  = (cur_x >= view_left) && (cur_x <= view_right) &&
                   (cur_y >= view_top) && (cur_y <= view_bottom);
  assign prev_in = (prev_x >= view_left) && (prev_x <= view_right) &&
                   (prev_y >= view_top) && (prev_y <= view_bottom);
  assign visible_next = first ? cur_in : (ctrl.hit | prev_in | cur_in);

  // Output slot.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctrl.done) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.done) begin
      visible <= visible_next;
    end
  end

  assign m_tdata = {{(OUT_DATA_W-1){1'b0}}, visible};

  psvc_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .start       (s_accept),
    .first_point (s_tuser),
    .out_free    (out_free),
    .res         (res),
    .step        (step),
    .ctrl        (ctrl)
  );

  psvc_cross_unit #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_cross (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .view_left   (view_left),
    .view_top    (view_top),
    .view_right  (view_right),
    .view_bottom (view_bottom),
    .prev_x      (prev_x),
    .prev_y      (prev_y),
    .cur_x       (cur_x),
    .cur_y       (cur_y),
    .res         (res)
  );

  `PSVC_ASSERT(a_busy_after_accept, clk, rst, s_accept |=> !s_tready, "ready right after accept")
  `PSVC_ASSERT(a_done_slot_free, clk, rst, ctrl.done |-> (!m_tvalid || m_tready), "result overwrites pending item")
  `PSVC_ASSERT(a_valid_from_done, clk, rst, $rose(m_tvalid) |-> $past(ctrl.done), "result without finished item")

endmodule
